/* sv/wrd_pkg.sv */
// Shared types and constants of the waveform record decoder.
package wrd_pkg;

  localparam int STRIDE_BITS_DEF = 12;
  localparam int DATA_W          = 8;
  localparam int RAW_W           = 17;
  localparam int INDEX_W         = 16;
  localparam int SCALE_W         = 32;
  localparam int OFFSET_W        = 25;
  localparam int SUM_W           = 26;
  localparam int PROD_W          = SUM_W + SCALE_W;
  localparam int VALUE_W         = 57;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [SCALE_W-1:0] SCALE_RESET = SCALE_W'(4294967);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TWO_BYTE   = 3'd0,
    REG_SIGNED     = 3'd1,
    REG_LITTLE_END = 3'd2,
    REG_KEEP_EVERY = 3'd3,
    REG_SCALE      = 3'd4,
    REG_OFFSET     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic two_byte_records;
    logic records_signed;
    logic little_endian;
  } fmt_cfg_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0]  scale_factor;
    logic signed [OFFSET_W-1:0] level_offset;
  } scale_cfg_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw;
    logic [INDEX_W-1:0]      index;
  } kept_rec_t;

endpackage

/* sv/wrd_if.sv */
// Valid/ready channel interfaces for raw bytes and decoded samples.
interface wrd_in_if
  import wrd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink (input valid, input data_byte, input block_start, output ready);
endinterface

interface wrd_out_if
  import wrd_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sample_value;
  logic [INDEX_W-1:0]        sample_index;

  modport source (output valid, output sample_value, output sample_index, input ready);
  modport sink (input valid, input sample_value, input sample_index, output ready);
endinterface

/* sv/waveform_record_decoder.sv */
// Top level of the waveform record decoder: configuration registers and the two pipeline halves.
// The block takes one raw data byte per clock with no gaps while the output is drained. A kept
// sample passes from the byte that completes its record through the record queue, the offset
// add register and the 26 by 32 bit multiplier register, with saturation on the way into the
// output register. When the output stalls, the three pipeline stages and the four-entry queue
// fill before the byte input stops. Registers take effect at once and are to be written only
// while the block is idle.
module waveform_record_decoder
  import wrd_pkg::*;
#(
  parameter int STRIDE_BITS = STRIDE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wrd_in_if.sink                in_chan,
  wrd_out_if.source             out_chan
);

  fmt_cfg_t               fmt_r;
  logic [STRIDE_BITS-1:0] keep_every_r;
  scale_cfg_t             scl_r;

  logic      push_valid;
  logic      push_ready;
  kept_rec_t push_rec;
  logic      pop_valid;
  logic      pop_ready;
  kept_rec_t pop_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r.two_byte_records <= 1'b0;
      fmt_r.records_signed   <= 1'b1;
      fmt_r.little_endian    <= 1'b0;
      keep_every_r           <= STRIDE_BITS'(1);
      scl_r.scale_factor     <= SCALE_RESET;
      scl_r.level_offset     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TWO_BYTE:   fmt_r.two_byte_records <= cfg_data[0];
        REG_SIGNED:     fmt_r.records_signed   <= cfg_data[0];
        REG_LITTLE_END: fmt_r.little_endian    <= cfg_data[0];
        REG_KEEP_EVERY: keep_every_r           <= cfg_data[STRIDE_BITS-1:0];
        REG_SCALE:      scl_r.scale_factor     <= cfg_data[SCALE_W-1:0];
        REG_OFFSET:     scl_r.level_offset     <= cfg_data[OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wrd_front #(
    .STRIDE_BITS(STRIDE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .fmt            (fmt_r),
    .keep_every     (keep_every_r),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_data_byte   (in_chan.data_byte),
    .in_block_start (in_chan.block_start),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_rec       (push_rec)
  );

  wrd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  wrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .scl       (scl_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec),
    .out_chan  (out_chan)
  );

endmodule

/* sv/wrd_front.sv */
// Front end: assembles records from bytes and picks the records to keep.
module wrd_front
  import wrd_pkg::*;
#(
  parameter int STRIDE_BITS = STRIDE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fmt_cfg_t               fmt,
  input  logic [STRIDE_BITS-1:0] keep_every,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [DATA_W-1:0]      in_data_byte,
  input  logic                   in_block_start,
  output logic                   push_valid,
  input  logic                   push_ready,
  output kept_rec_t              push_rec
);

  logic [DATA_W-1:0]      held_r;
  logic                   phase_r;
  logic [STRIDE_BITS-1:0] stride_r;
  logic [INDEX_W-1:0]     kept_r;

  logic                   acc;
  logic                   phase_e;
  logic [STRIDE_BITS-1:0] stride_e;
  logic [INDEX_W-1:0]     kept_e;
  logic                   record;
  logic                   keep;
  logic [15:0]            word;
  logic signed [RAW_W-1:0] raw;
  logic [STRIDE_BITS-1:0] stride_inc;
  logic [STRIDE_BITS-1:0] stride_lim;
  logic [STRIDE_BITS-1:0] stride_nxt;
  logic [INDEX_W-1:0]     kept_nxt;
  logic                   phase_nxt;

  assign in_ready = push_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    phase_e  = in_block_start ? 1'b0 : phase_r;
    stride_e = in_block_start ? '0 : stride_r;
    kept_e   = in_block_start ? '0 : kept_r;
    record   = !fmt.two_byte_records || phase_e;
    word     = fmt.little_endian ? {in_data_byte, held_r} : {held_r, in_data_byte};
    if (fmt.two_byte_records) begin
      raw = fmt.records_signed ? RAW_W'($signed(word)) : $signed({1'b0, word});
    end else begin
      raw = fmt.records_signed ? RAW_W'($signed(in_data_byte))
                               : $signed({9'd0, in_data_byte});
    end
    keep       = (stride_e == '0);
    stride_inc = stride_e + STRIDE_BITS'(1);
    stride_lim = (keep_every == '0) ? STRIDE_BITS'(1) : keep_every;
    phase_nxt  = fmt.two_byte_records && !phase_e;
    if (record) begin
      stride_nxt = (stride_inc >= stride_lim) ? '0 : stride_inc;
      kept_nxt   = keep ? kept_e + INDEX_W'(1) : kept_e;
    end else begin
      stride_nxt = stride_e;
      kept_nxt   = kept_e;
    end
  end

  assign push_valid     = acc && record && keep;
  assign push_rec.raw   = raw;
  assign push_rec.index = kept_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      stride_r <= '0;
      kept_r   <= '0;
      held_r   <= '0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      stride_r <= stride_nxt;
      kept_r   <= kept_nxt;
      if (phase_nxt) begin
        held_r <= in_data_byte;
      end
    end
  end

`ifndef SYNTHESIS
  a_one_byte_no_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !fmt.two_byte_records) |=> !phase_r)
    else $error("Byte phase set in one-byte mode.");
  a_start_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_block_start && fmt.two_byte_records) |=> phase_r)
    else $error("First byte of a block was not held.");
  a_kept_advances: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |=> (kept_r == $past(push_rec.index) + INDEX_W'(1)))
    else $error("Kept count did not advance after a kept record.");
`endif

endmodule

/* sv/wrd_queue.sv */
// Short queue of kept records between the front end and the scaler.
module wrd_queue
  import wrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  kept_rec_t push_rec,
  output logic      pop_valid,
  input  logic      pop_ready,
  output kept_rec_t pop_rec
);

  kept_rec_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_rec    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("Queue count exceeds its depth.");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == QPTR_W'(count_r))
    else $error("Queue pointers disagree with the count.");
  a_pop_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - QCNT_W'(1)))
    else $error("Queue count did not drop on a pop.");
`endif

endmodule

/* sv/wrd_back.sv */
// Back end: offsets, scales and saturates kept records in a stalling pipeline.
module wrd_back
  import wrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  scale_cfg_t scl,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  kept_rec_t  pop_rec,
  wrd_out_if.source  out_chan
);

  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  logic                      s1_v_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [INDEX_W-1:0]        s1_idx_r;
  logic                      s2_v_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [INDEX_W-1:0]        s2_idx_r;
  logic                      out_v_r;
  logic signed [VALUE_W-1:0] out_val_r;
  logic [INDEX_W-1:0]        out_idx_r;

  logic                      adv_o;
  logic                      adv_2;
  logic                      adv_1;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [VALUE_W-1:0] val_nxt;

  assign adv_o     = !out_v_r || out_chan.ready;
  assign adv_2     = !s2_v_r || adv_o;
  assign adv_1     = !s1_v_r || adv_2;
  assign pop_ready = adv_1;

  always_comb begin
    sum_nxt  = SUM_W'($signed({pop_rec.raw, 8'd0})) + SUM_W'(scl.level_offset);
    prod_nxt = sum_r * scl.scale_factor;
    if (prod_r[PROD_W-1] != prod_r[VALUE_W-1]) begin
      val_nxt = prod_r[PROD_W-1] ? VAL_MIN : VAL_MAX;
    end else begin
      val_nxt = prod_r[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv_1) begin
        s1_v_r <= pop_valid;
      end
      if (adv_2) begin
        s2_v_r <= s1_v_r;
      end
      if (adv_o) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_1 && pop_valid) begin
      sum_r    <= sum_nxt;
      s1_idx_r <= pop_rec.index;
    end
    if (adv_2 && s1_v_r) begin
      prod_r   <= prod_nxt;
      s2_idx_r <= s1_idx_r;
    end
    if (adv_o && s2_v_r) begin
      out_val_r <= val_nxt;
      out_idx_r <= s2_idx_r;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.sample_value = out_val_r;
  assign out_chan.sample_index = out_idx_r;

`ifndef SYNTHESIS
  a_s2_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !adv_o) |=> s2_v_r)
    else $error("Scaled product lost while the output stalled.");
  a_s1_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv_2) |=> (s1_v_r && $stable(sum_r)))
    else $error("Offset sum changed while the pipeline stalled.");
  a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_v_r && !s2_v_r) |=> !out_v_r)
    else $error("Output became valid without a product.");
`endif

endmodule
